// ----- hw/rtl/lcbas_pkg.sv -----
// shared types and constants for the load cell block average and settle unit
package lcbas_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned NET_W    = 13;
  localparam int unsigned VALUE_W  = 21;
  localparam int unsigned TOL_W    = 12;
  localparam int unsigned MATCH_W  = 8;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PROD_W   = NET_W + GAIN_W + 1;
  localparam int unsigned GAIN_FRAC_W = 8;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // queue sizes
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // register reset values
  localparam logic               MODE_RESET      = 1'b0;
  localparam logic [TOL_W-1:0]   TOL_RESET       = TOL_W'(3);
  localparam logic [MATCH_W-1:0] MATCH_RESET     = MATCH_W'(5);
  localparam logic [GAIN_W-1:0]  GAIN_RESET      = GAIN_W'(256);
  localparam logic [MATCH_W-1:0] MATCH_SATURATED = {MATCH_W{1'b1}};

  // register map, one word each
  typedef enum logic [1:0] {
    REG_MODE,
    REG_TOLERANCE,
    REG_MATCH_TARGET,
    REG_GAIN
  } reg_index_t;

  // operating modes
  localparam logic MODE_TARE  = 1'b0;
  localparam logic MODE_WEIGH = 1'b1;

  // result kinds
  localparam logic KIND_OFFSET = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [TOL_W-1:0]   tolerance;
    logic [MATCH_W-1:0] match_target;
    logic [GAIN_W-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic                      result_kind;
    logic signed [VALUE_W-1:0] value;
    logic signed [NET_W-1:0]   net_counts;
  } result_t;

endpackage

// ----- hw/rtl/lcbas_fifo.sv -----
// small synchronous queue used between the stages
module lcbas_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = store[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/lcbas_front.sv -----
// sample accumulator: sums each block and hands its average to the back end
module lcbas_front import lcbas_pkg::*; #(
  parameter int unsigned LOG2_BLOCK = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                full,
  input  logic                mid_full,
  output logic                mid_push,
  output logic [SAMPLE_W-1:0] mid_avg
);

  localparam int unsigned SUM_W = SAMPLE_W + LOG2_BLOCK;
  localparam int unsigned IDX_W = (LOG2_BLOCK > 0) ? LOG2_BLOCK : 1;

  logic [SUM_W-1:0] block_sum;
  logic [SUM_W-1:0] block_sum_next;
  logic [IDX_W-1:0] sample_index;
  logic             last;
  logic             accept;

  // block end is known before the beat arrives
  assign last     = (LOG2_BLOCK == 0) || (&sample_index);
  assign full     = last && mid_full;
  assign accept   = push && !full;

  assign block_sum_next = block_sum + SUM_W'(sample);
  assign mid_push       = accept && last;
  assign mid_avg        = block_sum_next[SUM_W-1:LOG2_BLOCK];

  // accumulator and index, cleared at every block end
  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum    <= '0;
      sample_index <= '0;
    end else if (accept) begin
      if (last) begin
        block_sum    <= '0;
        sample_index <= '0;
      end else begin
        block_sum    <= block_sum_next;
        sample_index <= sample_index + IDX_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/lcbas_back.sv -----
// block evaluator: tare, settle tracking and weight scaling
module lcbas_back import lcbas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 mid_valid,
  input  logic [SAMPLE_W-1:0]  mid_avg,
  output logic                 mid_pop,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_push,
  output result_t              out_data
);

  localparam int unsigned FLIGHT_W = OUT_CNT_W + 1;
  localparam int unsigned DIFF_W   = NET_W + 1;

  // settle state
  logic [SAMPLE_W-1:0]     offset_counts;
  logic [SAMPLE_W-1:0]     offset_counts_next;
  logic signed [NET_W-1:0] previous_average;
  logic signed [NET_W-1:0] previous_average_next;
  logic [MATCH_W-1:0]      match_count;
  logic [MATCH_W-1:0]      match_count_next;

  // decision stage
  logic                    s1_valid;
  logic                    s1_valid_next;
  logic                    s1_kind;
  logic                    s1_kind_next;
  logic signed [NET_W-1:0] s1_net;
  logic signed [NET_W-1:0] s1_net_next;
  logic [SAMPLE_W-1:0]     s1_avg;

  // multiply stage
  logic                     s2_valid;
  logic                     s2_kind;
  logic signed [NET_W-1:0]  s2_net;
  logic [SAMPLE_W-1:0]      s2_avg;
  logic signed [PROD_W-1:0] s2_product;
  logic signed [PROD_W-1:0] product;

  logic [FLIGHT_W-1:0]      in_flight;
  logic signed [NET_W-1:0]  net;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic                     matched;
  logic                     settled;

  // take a block only when the result queue has room for everything in flight
  assign in_flight = FLIGHT_W'(out_count) + FLIGHT_W'(s1_valid) + FLIGHT_W'(s2_valid);
  assign mid_pop   = mid_valid && (in_flight < FLIGHT_W'(OUT_DEPTH));

  // net counts and distance to the previous block
  assign net      = $signed({1'b0, mid_avg}) - $signed({1'b0, offset_counts});
  assign diff     = DIFF_W'(previous_average) - DIFF_W'(net);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign matched  = diff_mag < DIFF_W'(cfg.tolerance);
  assign settled  = match_count >= cfg.match_target;

  // per-block decision
  always_comb begin
    offset_counts_next    = offset_counts;
    previous_average_next = previous_average;
    match_count_next      = match_count;
    s1_valid_next         = 1'b0;
    s1_kind_next          = KIND_OFFSET;
    s1_net_next           = '0;
    if (mid_pop) begin
      priority if (cfg.mode == MODE_TARE) begin
        offset_counts_next = mid_avg;
        s1_valid_next      = 1'b1;
      end else if (settled) begin
        s1_valid_next         = 1'b1;
        s1_kind_next          = KIND_WEIGHT;
        s1_net_next           = net;
        match_count_next      = '0;
        previous_average_next = '0;
      end else begin
        previous_average_next = net;
        if (!matched) begin
          match_count_next = '0;
        end else if (match_count != MATCH_SATURATED) begin
          match_count_next = match_count + MATCH_W'(1);
        end
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_counts    <= '0;
      previous_average <= '0;
      match_count      <= '0;
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
    end else begin
      offset_counts    <= offset_counts_next;
      previous_average <= previous_average_next;
      match_count      <= match_count_next;
      s1_valid         <= s1_valid_next;
      s2_valid         <= s1_valid;
    end
  end

  // weight product, signed net times unsigned gain
  assign product = PROD_W'(s1_net) * PROD_W'($signed({1'b0, cfg.gain}));

  // payload pipeline
  always_ff @(posedge clk) begin
    s1_kind    <= s1_kind_next;
    s1_net     <= s1_net_next;
    s1_avg     <= mid_avg;
    s2_kind    <= s1_kind;
    s2_net     <= s1_net;
    s2_avg     <= s1_avg;
    s2_product <= product;
  end

  // floor divide by 256 is an arithmetic shift of the product
  assign out_push             = s2_valid;
  assign out_data.result_kind = s2_kind;
  assign out_data.net_counts  = s2_net;
  assign out_data.value       = (s2_kind == KIND_WEIGHT)
                              ? s2_product[GAIN_FRAC_W +: VALUE_W]
                              : $signed(VALUE_W'(s2_avg));

endmodule

// ----- hw/rtl/load_cell_block_average_settle_unit.sv -----
// load cell block averager with tare and settling detect, top level
// one sample per cycle back to back; full rises only at a block end with the block queue full
// a result is ready once the beat that closes its block has passed the block queue, decision stage,
// multiply stage and result queue write; at most one result per cycle
// reset is synchronous: queues, accumulator, settle state and registers return
// to their defaults
module load_cell_block_average_settle_unit import lcbas_pkg::*; #(
  parameter int unsigned LOG2_BLOCK = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  // samples
  input  logic                       push,
  input  logic [SAMPLE_W-1:0]        sample,
  output logic                       full,
  // results
  output logic                       empty,
  input  logic                       pop,
  output logic                       result_kind,
  output logic signed [VALUE_W-1:0]  value,
  output logic signed [NET_W-1:0]    net_counts
);

  cfg_t                 cfg;
  reg_index_t           reg_index;
  logic                 cfg_write;
  logic                 mid_full;
  logic                 mid_empty;
  logic                 mid_push;
  logic                 mid_pop;
  logic [SAMPLE_W-1:0]  mid_avg;
  logic [SAMPLE_W-1:0]  mid_head;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                 out_push;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_full;
  result_t              out_data;
  result_t              out_head;

  // register port
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_RESET;
      cfg.tolerance    <= TOL_RESET;
      cfg.match_target <= MATCH_RESET;
      cfg.gain         <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_MODE:         cfg.mode         <= pwdata[0];
        REG_TOLERANCE:    cfg.tolerance    <= pwdata[TOL_W-1:0];
        REG_MATCH_TARGET: cfg.match_target <= pwdata[MATCH_W-1:0];
        REG_GAIN:         cfg.gain         <= pwdata[GAIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_index)
      REG_MODE:         prdata = DATA_W'(cfg.mode);
      REG_TOLERANCE:    prdata = DATA_W'(cfg.tolerance);
      REG_MATCH_TARGET: prdata = DATA_W'(cfg.match_target);
      REG_GAIN:         prdata = DATA_W'(cfg.gain);
      default:          prdata = '0;
    endcase
  end

  // front end
  lcbas_front #(
    .LOG2_BLOCK(LOG2_BLOCK)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .full     (full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_avg  (mid_avg)
  );

  // block averages waiting for the back end
  lcbas_fifo #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_avg),
    .pop     (mid_pop),
    .rd_data (mid_head),
    .empty   (mid_empty),
    .full    (mid_full),
    .count   (mid_count)
  );

  // back end
  lcbas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_valid (!mid_empty),
    .mid_avg   (mid_head),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  // result queue
  lcbas_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_data),
    .pop     (pop),
    .rd_data (out_head),
    .empty   (empty),
    .full    (out_full),
    .count   (out_count)
  );

  assign result_kind = out_head.result_kind;
  assign value       = out_head.value;
  assign net_counts  = out_head.net_counts;

endmodule

// ----- hw/rtl/lcbas_checker.sv -----
// port-level checks for the load cell block average and settle unit
module lcbas_checker import lcbas_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic                      result_kind,
  input logic signed [VALUE_W-1:0] value,
  input logic signed [NET_W-1:0]   net_counts
);

  // reset leaves both sides drained
  a_reset_drained: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not drained after reset");

  // an offset beat always carries zero net counts
  a_offset_net_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_OFFSET) |-> (net_counts == '0))
    else $error("offset beat with nonzero net counts");

  // an offset is a plain 12-bit count
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_OFFSET) |-> (value[VALUE_W-1:SAMPLE_W] == '0))
    else $error("offset beat out of range");

  // a waiting beat holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(net_counts)
                          && $stable(result_kind)))
    else $error("waiting result beat changed");

endmodule

bind load_cell_block_average_settle_unit lcbas_checker u_lcbas_checker (.*);
